>>> hw/rtl/indexed_list_insert_remove_top_macros.svh
`ifndef INDEXED_LIST_INSERT_REMOVE_TOP_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_TOP_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ILIR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ILIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ILIR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ilir_pkg.sv
`default_nettype none

package ilir_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int POS_W        = 5;
    localparam int CNT_W        = 5;
    localparam int WORD_W       = 32;

    localparam logic [WORD_W-1:0] ERR_WORD = '1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/ilir_cell.sv
`default_nettype none

module ilir_cell
    import ilir_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CMP_W = 5
)
(
    input  wire logic              clk,
    input  wire cell_cmd_t         cmd,
    input  wire logic [WORD_W-1:0] prev_word,
    input  wire logic [WORD_W-1:0] next_word,
    output logic [WORD_W-1:0]      word,
    output logic [WORD_W-1:0]      sel_word
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [CMP_W-1:0]  pos_ext;

    assign pos_ext = CMP_W'(cmd.pos);

    always_comb
    begin
        word_next = word_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > pos_ext)
                word_next = prev_word;
            else if (MY_IDX == pos_ext)
                word_next = cmd.value;
        end
        else if (cmd.rem)
        begin
            if (MY_IDX >= pos_ext)
                word_next = next_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign sel_word = (MY_IDX == pos_ext) ? word_reg : '0;

endmodule

`default_nettype wire

>>> hw/rtl/indexed_list_insert_remove_top.sv
// channel  | handshake       | payload
// ---------+-----------------+-------------------------------
// request  | start / busy    | func, position, value
// result   | done (strobe)   | data_out, status, count
//
// one request is taken per cycle; busy stays low, each list cell shifts,
// holds or loads locally so insert and remove complete without any stall
// the result is registered and strobed on done the cycle after the transfer
// reset clears the fill count and result strobe; cell words are left as is
// the receiver cannot stall, so results are never held back
`default_nettype none

module indexed_list_insert_remove_top
    import ilir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        func,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [WORD_W-1:0] value,
    output logic                   done,
    output logic [WORD_W-1:0]      data_out,
    output logic [1:0]             status,
    output logic [CNT_W-1:0]       count
);

    `include "indexed_list_insert_remove_top_macros.svh"

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;
    localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(CAPACITY);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              done_reg;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    status_t           status_reg;
    status_t           status_next;
    logic [CNT_W-1:0]  count_reg;

    logic              accept;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  fill_ext;
    cell_cmd_t         cmd;
    logic [WORD_W-1:0] rd_word;

    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic [WORD_W-1:0] cell_sel  [CAPACITY];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign pos_ext  = CMP_W'(position);
    assign fill_ext = CMP_W'(fill_reg);

    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_word = rd_word | cell_sel[i];
    end

    always_comb
    begin
        cmd.ins     = 1'b0;
        cmd.rem     = 1'b0;
        cmd.pos     = position;
        cmd.value   = value;
        fill_next   = fill_reg;
        data_next   = ERR_WORD;
        status_next = ST_BADPOS;
        unique case (op_t'(func))
            OP_INSERT:
            begin
                if (pos_ext > fill_ext)
                    status_next = ST_BADPOS;
                else if (fill_reg >= FULL_CNT)
                    status_next = ST_FULL;
                else
                begin
                    cmd.ins     = accept;
                    fill_next   = fill_reg + FILL_W'(1);
                    data_next   = '0;
                    status_next = ST_OK;
                end
            end
            OP_REMOVE, OP_READ:
            begin
                if (fill_reg == '0)
                    status_next = ST_EMPTY;
                else if (pos_ext >= fill_ext)
                    status_next = ST_BADPOS;
                else
                begin
                    data_next   = rd_word;
                    status_next = ST_OK;
                    if (op_t'(func) == OP_REMOVE)
                    begin
                        cmd.rem   = accept;
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end
            end
            default:
            begin
                status_next = ST_BADPOS;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [WORD_W-1:0] prev_w;
        logic [WORD_W-1:0] next_w;

        if (g == 0)
        begin : g_first
            assign prev_w = cell_word[g];
        end
        else
        begin : g_mid_prev
            assign prev_w = cell_word[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_w = cell_word[g];
        end
        else
        begin : g_mid_next
            assign next_w = cell_word[g+1];
        end

        ilir_cell #(
            .IDX   (g),
            .CMP_W (CMP_W)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (cell_word[g]),
            .sel_word  (cell_sel[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                fill_reg  <= fill_next;
                count_reg <= CNT_W'(fill_next);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign done     = done_reg;
    assign data_out = data_reg;
    assign status   = status_reg;
    assign count    = count_reg;

    `ILIR_ASSERT_NEXT(a_result_follows, accept, done, "no result after transfer")
    `ILIR_ASSERT_NEXT(a_no_spurious, !accept, !done, "result without transfer")
    `ILIR_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FULL_CNT, "fill count above capacity")
    `ILIR_ASSERT_SAME(a_err_word, done && (status_reg != ST_OK), data_reg == ERR_WORD,
        "error result without error word")

endmodule

`default_nettype wire
